[design/mrfc_pkg.sv]
// Shared types, constants and CRC function for the meter reply frame checker.
`default_nettype none

package mrfc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  EXC_FUNC = 8'h84;

  // Bytes 0..20 cover every field that the decoder looks at.
  localparam int MEAS_BYTES = 21;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CRC_ERR   = 2'd1;
  localparam logic [1:0] ST_EXCEPTION = 2'd2;
  localparam logic [1:0] ST_SHORT     = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  exception_code;
    logic [15:0] voltage_raw;
    logic [31:0] current_raw;
    logic [31:0] power_raw;
    logic [31:0] energy_raw;
    logic [15:0] frequency_raw;
    logic [15:0] power_factor_raw;
  } result_t;

  // Reflected CRC-16/Modbus update over one byte, one bit per step.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/mrfc_decode.sv]
// Frame judgment and field extraction for one completed reply frame.
`default_nettype none

module mrfc_decode #(
  parameter int FRAME_BYTES = 25
) (
  input  wire logic [FRAME_BYTES-1:0][7:0]          frame,
  input  wire logic [$clog2(FRAME_BYTES+1)-1:0]     count,
  input  wire logic [15:0]                          crc,
  output mrfc_pkg::result_t                         result
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  logic [mrfc_pkg::MEAS_BYTES-1:0][7:0] b;

  // Bytes beyond the frame length read as zero.
  for (genvar i = 0; i < mrfc_pkg::MEAS_BYTES; i++) begin : g_pad
    if (i < FRAME_BYTES) begin : g_in
      assign b[i] = frame[i];
    end else begin : g_out
      assign b[i] = 8'h00;
    end
  end

  always_comb begin
    result = '0;
    if (count <= CNT_W'(2) || crc != 16'h0000) begin
      result.status = mrfc_pkg::ST_CRC_ERR;
    end else if (b[1] == mrfc_pkg::EXC_FUNC) begin
      result.status         = mrfc_pkg::ST_EXCEPTION;
      result.exception_code = b[2];
    end else if (count < CNT_W'(FRAME_BYTES)) begin
      result.status = mrfc_pkg::ST_SHORT;
    end else begin
      // 32-bit values arrive low word first, each word big-endian.
      result.status           = mrfc_pkg::ST_OK;
      result.voltage_raw      = {b[3], b[4]};
      result.current_raw      = {b[7], b[8], b[5], b[6]};
      result.power_raw        = {b[11], b[12], b[9], b[10]};
      result.energy_raw       = {b[15], b[16], b[13], b[14]};
      result.frequency_raw    = {b[17], b[18]};
      result.power_factor_raw = {b[19], b[20]};
    end
  end

endmodule

`default_nettype wire

[design/meter_reply_frame_checker.sv]
// Top level of the meter reply frame checker: byte intake, CRC, store and result register.
`default_nettype none

// Takes one byte transaction per clock and keeps a running CRC-16/Modbus and
// a store of the first FRAME_BYTES bytes of the frame in flip-flops. The
// transaction that carries end_of_frame is judged in the same cycle, with its
// own byte included, and its result is registered for the output in the cycle
// after; byte count and CRC are back at reset values for the very next transaction.
// Sustained rate is one transaction per cycle. The input stalls only while a
// result sits in the output register and the consumer does not take it.
module meter_reply_frame_checker #(
  parameter int FRAME_BYTES = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        byte_valid,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        end_of_frame,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  status,
  output      logic [7:0]  exception_code,
  output      logic [15:0] voltage_raw,
  output      logic [31:0] current_raw,
  output      logic [31:0] power_raw,
  output      logic [31:0] energy_raw,
  output      logic [15:0] frequency_raw,
  output      logic [15:0] power_factor_raw
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_BYTES);

  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic [15:0]                 crc;
  logic [15:0]                 crc_next;
  logic [FRAME_BYTES-1:0][7:0] frame;
  logic [FRAME_BYTES-1:0][7:0] frame_next;
  logic                        in_fire;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_idx;
  mrfc_pkg::result_t           dec_result;
  mrfc_pkg::result_t           result;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = in_fire && byte_valid && (count < CNT_W'(FRAME_BYTES));
  assign wr_idx   = count[IDX_W-1:0];

  assign count_next = wr_en ? count + CNT_W'(1) : count;
  assign crc_next   = wr_en ? mrfc_pkg::crc16_update(crc, rx_byte) : crc;

  // View of the store with this transaction's byte already in place.
  always_comb begin
    frame_next = frame;
    if (wr_en) begin
      frame_next[wr_idx] = rx_byte;
    end
  end

  mrfc_decode #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_decode (
    .frame  (frame_next),
    .count  (count_next),
    .crc    (crc_next),
    .result (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      crc       <= mrfc_pkg::CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (in_fire && end_of_frame) begin
        count <= '0;
        crc   <= mrfc_pkg::CRC_INIT;
      end else begin
        count <= count_next;
        crc   <= crc_next;
      end
      if (in_fire && end_of_frame) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    frame <= frame_next;
    if (in_fire && end_of_frame) begin
      result <= dec_result;
    end
  end

  assign status           = result.status;
  assign exception_code   = result.exception_code;
  assign voltage_raw      = result.voltage_raw;
  assign current_raw      = result.current_raw;
  assign power_raw        = result.power_raw;
  assign energy_raw       = result.energy_raw;
  assign frequency_raw    = result.frequency_raw;
  assign power_factor_raw = result.power_factor_raw;

`ifndef SYNTHESIS
  a_result_from_eof: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && end_of_frame))
    else $error("result appeared without an end-of-frame transaction");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && end_of_frame) |=>
      (out_valid && count == '0 && crc == mrfc_pkg::CRC_INIT))
    else $error("frame state not restarted after end of frame");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FRAME_BYTES))
    else $error("byte count ran past the store depth");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != mrfc_pkg::ST_OK) |->
      (voltage_raw == '0 && current_raw == '0 && power_raw == '0 &&
       energy_raw == '0 && frequency_raw == '0 && power_factor_raw == '0))
    else $error("measurement fields set on a failed frame");

  a_exc_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != mrfc_pkg::ST_EXCEPTION) |-> exception_code == '0)
    else $error("exception code set without an exception status");
`endif

endmodule

`default_nettype wire
